@@ rtl/ofdmcp_pkg.sv @@
// shared types and constants for the cyclic prefix inserter with sync underlay
package ofdmcp_pkg;

	typedef enum logic [1:0] {
		ACT_PUSH       = 2'd0,
		ACT_PULL       = 2'd1,
		ACT_LOAD_SHORT = 2'd2,
		ACT_LOAD_LONG  = 2'd3
	} action_t;

	localparam int CFG_AW = 3;
	localparam int CFG_DW = 24;

	localparam logic [CFG_AW-1:0] CFG_SYMBOL_LEN  = 3'd0;
	localparam logic [CFG_AW-1:0] CFG_PREFIX_LEN  = 3'd1;
	localparam logic [CFG_AW-1:0] CFG_SHORT_LEN   = 3'd2;
	localparam logic [CFG_AW-1:0] CFG_SHORT_REPS  = 3'd3;
	localparam logic [CFG_AW-1:0] CFG_LONG_LEN    = 3'd4;
	localparam logic [CFG_AW-1:0] CFG_PAYLOAD_LEN = 3'd5;
	localparam logic [CFG_AW-1:0] CFG_SYNC_GAIN   = 3'd6;

	localparam int SYMBOL_LEN_W  = 11;
	localparam int PREFIX_LEN_W  = 11;
	localparam int SHORT_LEN_W   = 9;
	localparam int SHORT_REPS_W  = 8;
	localparam int LONG_LEN_W    = 9;
	localparam int PAYLOAD_LEN_W = 24;
	localparam int GAIN_W        = 16;
	localparam int GAIN_FRAC     = 12;
	localparam int ENTRY_W       = 16;
	localparam int TIDX_W        = 8;
	localparam int SREG_W        = SHORT_REPS_W + SHORT_LEN_W;
	localparam int SLEND_W       = SREG_W + 1;
	localparam int FRAME_W       = 25;

	localparam logic [SYMBOL_LEN_W-1:0]  RST_SYMBOL_LEN  = 11'd64;
	localparam logic [PREFIX_LEN_W-1:0]  RST_PREFIX_LEN  = 11'd16;
	localparam logic [SHORT_LEN_W-1:0]   RST_SHORT_LEN   = 9'd16;
	localparam logic [SHORT_REPS_W-1:0]  RST_SHORT_REPS  = 8'd10;
	localparam logic [LONG_LEN_W-1:0]    RST_LONG_LEN    = 9'd160;
	localparam logic [PAYLOAD_LEN_W-1:0] RST_PAYLOAD_LEN = 24'd800;
	localparam logic [GAIN_W-1:0]        RST_SYNC_GAIN   = 16'd4096;

	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic add_en;
		logic overrun;
		logic symbol_end;
		logic valid_res;
	} pull_flags_t;

	typedef struct packed {
		logic overrun;
		logic clipped;
		logic valid_res;
	} out_flags_t;

endpackage

@@ rtl/ofdm_cp_insert_with_sync_underlay.sv @@
// top level of the cyclic prefix inserter with sync sequence underlay
// One beat is taken per clock while s_tready is high: pushes and table loads only write
// memory, a pull reads the symbol buffer and the sequence table in the front part and is
// offered on m_tvalid after passing the memory read register, the queue, the gain
// multiply stage and the output register. s_tready drops for one cycle after each config
// write while the derived symbol and frame lengths are refreshed, and when the four-beat
// queue is taken up under output back-pressure. There is no clearing pass after reset;
// symbol buffer and sequence tables hold junk until written.
module ofdm_cp_insert_with_sync_underlay #(
	parameter int MAX_SYMBOL  = 1024,
	parameter int MAX_SEQ     = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [ofdmcp_pkg::CFG_AW-1:0]          cfg_addr,
	input  logic [ofdmcp_pkg::CFG_DW-1:0]          cfg_data,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// sample_re, sample_im, table_index, entry_re, entry_im
	input  logic [((2*SAMPLE_BITS+40+7)/8)*8-1:0]  s_tdata,
	// action
	input  logic [1:0]                             s_tuser,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// out_re, out_im
	output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,
	// valid_res, clipped, overrun
	output logic [2:0]                             m_tuser,
	output logic                                   m_tlast
);

	import ofdmcp_pkg::*;

	localparam int SB     = SAMPLE_BITS;
	localparam int OUT_TW = ((2 * SAMPLE_BITS + 7) / 8) * 8;
	localparam int FL_W   = $bits(pull_flags_t);
	localparam int Q_W    = FL_W + 2 * ENTRY_W + 2 * SB;

	logic [SB-1:0]      sample_re, sample_im;
	logic [TIDX_W-1:0]  table_index;
	logic [ENTRY_W-1:0] entry_re, entry_im;

	logic               q_push;
	pull_flags_t        q_flags;
	logic [SB-1:0]      q_smp_re, q_smp_im;
	logic [ENTRY_W-1:0] q_ent_re, q_ent_im;
	logic [GAIN_W-1:0]  sync_gain;
	logic [QCNT_W-1:0]  q_count;
	logic               q_pop;
	logic               q_head_valid;
	logic [Q_W-1:0]     q_head;
	pull_flags_t        h_flags;

	logic signed [SB-1:0] out_re, out_im;
	logic               symbol_end;
	out_flags_t         out_flags;

	assign sample_re   = s_tdata[SB-1:0];
	assign sample_im   = s_tdata[2*SB-1:SB];
	assign table_index = s_tdata[2*SB+TIDX_W-1:2*SB];
	assign entry_re    = s_tdata[2*SB+TIDX_W+ENTRY_W-1:2*SB+TIDX_W];
	assign entry_im    = s_tdata[2*SB+TIDX_W+2*ENTRY_W-1:2*SB+TIDX_W+ENTRY_W];

	ofdmcp_front #(
		.MAX_SYMBOL (MAX_SYMBOL),
		.MAX_SEQ    (MAX_SEQ),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_addr   (cfg_addr),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.action     (action_t'(s_tuser)),
		.sample_re  (sample_re),
		.sample_im  (sample_im),
		.table_index(table_index),
		.entry_re   (entry_re),
		.entry_im   (entry_im),
		.q_count    (q_count),
		.q_push     (q_push),
		.q_flags    (q_flags),
		.q_smp_re   (q_smp_re),
		.q_smp_im   (q_smp_im),
		.q_ent_re   (q_ent_re),
		.q_ent_im   (q_ent_im),
		.sync_gain  (sync_gain)
	);

	ofdmcp_fifo #(
		.WIDTH(Q_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data ({q_flags, q_ent_im, q_ent_re, q_smp_im, q_smp_re}),
		.pop       (q_pop),
		.head_valid(q_head_valid),
		.head_data (q_head),
		.count     (q_count)
	);

	assign h_flags = q_head[Q_W-1:Q_W-FL_W];

	ofdmcp_back #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_head_valid),
		.q_pop     (q_pop),
		.q_flags   (h_flags),
		.q_smp_re  ($signed(q_head[SB-1:0])),
		.q_smp_im  ($signed(q_head[2*SB-1:SB])),
		.q_ent_re  ($signed(q_head[2*SB+ENTRY_W-1:2*SB])),
		.q_ent_im  ($signed(q_head[2*SB+2*ENTRY_W-1:2*SB+ENTRY_W])),
		.sync_gain (sync_gain),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.out_re    (out_re),
		.out_im    (out_im),
		.symbol_end(symbol_end),
		.out_flags (out_flags)
	);

	assign m_tdata = OUT_TW'({out_im, out_re});
	assign m_tuser = out_flags;
	assign m_tlast = symbol_end;

endmodule

@@ rtl/ofdmcp_ram.sv @@
// generic single write port ram with registered read
module ofdmcp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ rtl/ofdmcp_fifo.sv @@
// small register queue between the front and back parts
module ofdmcp_fifo #(
	parameter int WIDTH = 72,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           push_data,
	input  logic                       pop,
	output logic                       head_valid,
	output logic [WIDTH-1:0]           head_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign count      = count_q;

endmodule

@@ rtl/ofdmcp_front.sv @@
// front part: config, beat classification, buffer and table control, memory reads
module ofdmcp_front #(
	parameter int MAX_SYMBOL  = 1024,
	parameter int MAX_SEQ     = 256,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ofdmcp_pkg::CFG_AW-1:0]      cfg_addr,
	input  logic [ofdmcp_pkg::CFG_DW-1:0]      cfg_data,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  ofdmcp_pkg::action_t                action,
	input  logic [SAMPLE_BITS-1:0]             sample_re,
	input  logic [SAMPLE_BITS-1:0]             sample_im,
	input  logic [ofdmcp_pkg::TIDX_W-1:0]      table_index,
	input  logic [ofdmcp_pkg::ENTRY_W-1:0]     entry_re,
	input  logic [ofdmcp_pkg::ENTRY_W-1:0]     entry_im,
	input  logic [ofdmcp_pkg::QCNT_W-1:0]      q_count,
	output logic                               q_push,
	output ofdmcp_pkg::pull_flags_t            q_flags,
	output logic [SAMPLE_BITS-1:0]             q_smp_re,
	output logic [SAMPLE_BITS-1:0]             q_smp_im,
	output logic [ofdmcp_pkg::ENTRY_W-1:0]     q_ent_re,
	output logic [ofdmcp_pkg::ENTRY_W-1:0]     q_ent_im,
	output logic [ofdmcp_pkg::GAIN_W-1:0]      sync_gain
);

	import ofdmcp_pkg::*;

	localparam int LW          = $clog2(MAX_SYMBOL + 1);
	localparam int TW          = LW + 1;
	localparam int SYM_AW      = $clog2(MAX_SYMBOL);
	localparam int ST_AW       = $clog2(2 * MAX_SYMBOL);
	localparam int SEQ_AW      = $clog2(MAX_SEQ);
	localparam int TB_AW       = $clog2(2 * MAX_SEQ);
	localparam int SPOS_W      = SHORT_LEN_W;
	localparam int SPOS_MAX    = (1 << SPOS_W) - 1;

	function automatic int mod_steps();
		int n;
		n = 0;
		for (int k = 0; k < 10; k++) begin
			if ((MAX_SEQ * (2 ** k)) <= SPOS_MAX) begin
				n = k + 1;
			end
		end
		return n;
	endfunction

	localparam int MOD_STEPS = mod_steps();

	function automatic logic [SEQ_AW-1:0] seq_mod(input logic [SPOS_W-1:0] v);
		logic [SPOS_W-1:0] r;
		r = v;
		for (int k = MOD_STEPS - 1; k >= 0; k--) begin
			if (32'(r) >= (MAX_SEQ << k)) begin
				r = r - SPOS_W'(MAX_SEQ << k);
			end
		end
		return SEQ_AW'(r);
	endfunction

	// config registers
	logic [SYMBOL_LEN_W-1:0]  symbol_len_q;
	logic [PREFIX_LEN_W-1:0]  prefix_len_q;
	logic [SHORT_LEN_W-1:0]   short_len_q;
	logic [SHORT_REPS_W-1:0]  short_reps_q;
	logic [LONG_LEN_W-1:0]    long_len_q;
	logic [PAYLOAD_LEN_W-1:0] payload_len_q;
	logic [GAIN_W-1:0]        sync_gain_q;
	logic                     settle_q;

	// derived lengths
	logic [LW-1:0]      eff_l_d, eff_l_q;
	logic [LW-1:0]      eff_p_d, eff_p_q;
	logic [TW-1:0]      total_d, total_q;
	logic [LW-1:0]      lmp_d, lmp_q;
	logic [SREG_W-1:0]  short_region_d, short_region_q;
	logic [SLEND_W-1:0] short_long_end_d, short_long_end_q;
	logic [FRAME_W-1:0] frame_len_d, frame_len_q;

	// buffer and frame state
	logic [LW-1:0]      write_count_q;
	logic               write_bank_q;
	logic [1:0]         bank_full_q;
	logic [TW-1:0]      read_pos_q;
	logic               read_bank_q;
	logic [FRAME_W-1:0] frame_pos_q;
	logic [SPOS_W-1:0]  short_pos_q;
	logic               drop_flag_q;

	logic               pull_s1;
	pull_flags_t        flags_s1;

	logic               accept;
	logic               is_push;
	logic               is_pull;
	logic               is_load;
	logic               pull_valid;

	logic [LW-1:0]      wc_inc;
	logic               wc_full;
	logic [ST_AW-1:0]   st_waddr;
	logic               st_we;
	logic [ST_AW-1:0]   st_raddr;
	logic [2*SAMPLE_BITS-1:0] st_rdata;

	logic               tb_we;
	logic [TB_AW-1:0]   tb_waddr;
	logic [TB_AW-1:0]   tb_raddr;
	logic [2*ENTRY_W-1:0] tb_rdata;

	logic [TW-1:0]      rp;
	logic [TW-1:0]      rp_inc;
	logic [TW-1:0]      idx_sum;
	logic [SYM_AW-1:0]  idx;
	logic               pull_end;
	logic [FRAME_W-1:0] fp;
	logic [FRAME_W-1:0] fp_off;
	logic [SPOS_W-1:0]  sp_z;
	logic [SPOS_W-1:0]  sp_u;
	logic [SPOS_W:0]    sp_inc;
	logic [SPOS_W-1:0]  sp_next;
	logic               in_short;
	logic               in_long;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_len_q  <= RST_SYMBOL_LEN;
			prefix_len_q  <= RST_PREFIX_LEN;
			short_len_q   <= RST_SHORT_LEN;
			short_reps_q  <= RST_SHORT_REPS;
			long_len_q    <= RST_LONG_LEN;
			payload_len_q <= RST_PAYLOAD_LEN;
			sync_gain_q   <= RST_SYNC_GAIN;
			settle_q      <= 1'b1;
		end else begin
			settle_q <= cfg_we;
			if (cfg_we) begin
				case (cfg_addr)
					CFG_SYMBOL_LEN:  symbol_len_q  <= cfg_data[SYMBOL_LEN_W-1:0];
					CFG_PREFIX_LEN:  prefix_len_q  <= cfg_data[PREFIX_LEN_W-1:0];
					CFG_SHORT_LEN:   short_len_q   <= cfg_data[SHORT_LEN_W-1:0];
					CFG_SHORT_REPS:  short_reps_q  <= cfg_data[SHORT_REPS_W-1:0];
					CFG_LONG_LEN:    long_len_q    <= cfg_data[LONG_LEN_W-1:0];
					CFG_PAYLOAD_LEN: payload_len_q <= cfg_data[PAYLOAD_LEN_W-1:0];
					CFG_SYNC_GAIN:   sync_gain_q   <= cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		if (symbol_len_q == '0) begin
			eff_l_d = LW'(1);
		end else if (32'(symbol_len_q) > MAX_SYMBOL) begin
			eff_l_d = LW'(MAX_SYMBOL);
		end else begin
			eff_l_d = LW'(symbol_len_q);
		end
		if (32'(prefix_len_q) > 32'(eff_l_d)) begin
			eff_p_d = eff_l_d;
		end else begin
			eff_p_d = LW'(prefix_len_q);
		end
		total_d          = {1'b0, eff_l_d} + {1'b0, eff_p_d};
		lmp_d            = eff_l_d - eff_p_d;
		short_region_d   = SREG_W'(short_reps_q) * SREG_W'(short_len_q);
		short_long_end_d = SLEND_W'(short_region_d) + SLEND_W'(long_len_q);
		frame_len_d      = FRAME_W'(short_long_end_d) + FRAME_W'(payload_len_q);
	end

	always_ff @(posedge clk) begin
		eff_l_q          <= eff_l_d;
		eff_p_q          <= eff_p_d;
		total_q          <= total_d;
		lmp_q            <= lmp_d;
		short_region_q   <= short_region_d;
		short_long_end_q <= short_long_end_d;
		frame_len_q      <= frame_len_d;
	end

	assign s_tready = !settle_q
		&& ((QCNT_W'(q_count) + QCNT_W'(pull_s1)) < QCNT_W'(QUEUE_DEPTH));
	assign accept   = s_tvalid && s_tready;
	assign is_push  = (action == ACT_PUSH);
	assign is_pull  = (action == ACT_PULL);
	assign is_load  = (action == ACT_LOAD_SHORT) || (action == ACT_LOAD_LONG);
	assign pull_valid = bank_full_q[read_bank_q];

	// push side
	assign wc_inc  = write_count_q + LW'(1);
	assign wc_full = (wc_inc >= eff_l_q);
	assign st_we   = accept && is_push && !bank_full_q[write_bank_q];
	assign st_waddr = write_bank_q
		? ST_AW'(MAX_SYMBOL) + ST_AW'(write_count_q[SYM_AW-1:0])
		: ST_AW'(write_count_q[SYM_AW-1:0]);

	// table loads
	assign tb_we    = accept && is_load && (32'(table_index) < MAX_SEQ);
	assign tb_waddr = (action == ACT_LOAD_LONG)
		? TB_AW'(MAX_SEQ) + TB_AW'(table_index)
		: TB_AW'(table_index);

	// pull side
	always_comb begin
		rp      = (read_pos_q >= total_q) ? total_q - TW'(1) : read_pos_q;
		rp_inc  = rp + TW'(1);
		if (rp < {1'b0, eff_p_q}) begin
			idx_sum = {1'b0, lmp_q} + rp;
		end else begin
			idx_sum = rp - {1'b0, eff_p_q};
		end
		idx      = idx_sum[SYM_AW-1:0];
		pull_end = (rp_inc >= total_q);
		st_raddr = read_bank_q ? ST_AW'(MAX_SYMBOL) + ST_AW'(idx) : ST_AW'(idx);

		fp       = (frame_pos_q >= frame_len_q) ? '0 : frame_pos_q;
		sp_z     = (fp == '0) ? '0 : short_pos_q;
		in_short = (fp < FRAME_W'(short_region_q));
		in_long  = !in_short && (fp < FRAME_W'(short_long_end_q));
		sp_u     = (sp_z >= short_len_q) ? '0 : sp_z;
		sp_inc   = {1'b0, sp_u} + (SPOS_W + 1)'(1);
		sp_next  = (sp_inc >= {1'b0, short_len_q}) ? '0 : sp_inc[SPOS_W-1:0];
		fp_off   = fp - FRAME_W'(short_region_q);
		if (in_short) begin
			tb_raddr = TB_AW'(seq_mod(sp_u));
		end else begin
			tb_raddr = TB_AW'(MAX_SEQ) + TB_AW'(seq_mod(fp_off[SPOS_W-1:0]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_count_q <= '0;
			write_bank_q  <= 1'b0;
			bank_full_q   <= '0;
			read_pos_q    <= '0;
			read_bank_q   <= 1'b0;
			frame_pos_q   <= '0;
			short_pos_q   <= '0;
			drop_flag_q   <= 1'b0;
			pull_s1       <= 1'b0;
		end else begin
			pull_s1 <= accept && is_pull;
			if (accept) begin
				case (action)
					ACT_PUSH: begin
						if (bank_full_q[write_bank_q]) begin
							drop_flag_q <= 1'b1;
						end else if (wc_full) begin
							bank_full_q[write_bank_q] <= 1'b1;
							write_bank_q              <= !write_bank_q;
							write_count_q             <= '0;
						end else begin
							write_count_q <= wc_inc;
						end
					end
					ACT_PULL: begin
						drop_flag_q <= 1'b0;
						if (pull_valid) begin
							frame_pos_q <= fp + FRAME_W'(1);
							short_pos_q <= in_short ? sp_next : sp_z;
							if (pull_end) begin
								read_pos_q               <= '0;
								bank_full_q[read_bank_q] <= 1'b0;
								read_bank_q              <= !read_bank_q;
							end else begin
								read_pos_q <= rp_inc;
							end
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		flags_s1.valid_res  <= pull_valid;
		flags_s1.symbol_end <= pull_valid && pull_end;
		flags_s1.overrun    <= drop_flag_q;
		flags_s1.add_en     <= pull_valid && (in_short || in_long);
	end

	ofdmcp_ram #(
		.WIDTH(2 * SAMPLE_BITS),
		.DEPTH(2 * MAX_SYMBOL)
	) u_store (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata({sample_im, sample_re}),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	ofdmcp_ram #(
		.WIDTH(2 * ENTRY_W),
		.DEPTH(2 * MAX_SEQ)
	) u_seq_table (
		.clk  (clk),
		.we   (tb_we),
		.waddr(tb_waddr),
		.wdata({entry_im, entry_re}),
		.raddr(tb_raddr),
		.rdata(tb_rdata)
	);

	assign q_push    = pull_s1;
	assign q_flags   = flags_s1;
	assign q_smp_re  = st_rdata[SAMPLE_BITS-1:0];
	assign q_smp_im  = st_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
	assign q_ent_re  = tb_rdata[ENTRY_W-1:0];
	assign q_ent_im  = tb_rdata[2*ENTRY_W-1:ENTRY_W];
	assign sync_gain = sync_gain_q;

`ifndef ASSERT_OFF
	a_banks_even: assert property (@(posedge clk) disable iff (!arst_n)
		(bank_full_q == 2'b00 || bank_full_q == 2'b11) |-> (write_bank_q == read_bank_q))
		else $error("write and read bank disagree");

	a_bank_one: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(bank_full_q) |-> (bank_full_q[read_bank_q] && !bank_full_q[write_bank_q]))
		else $error("single full bank not at read side");

	a_add_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(pull_s1 && flags_s1.add_en) |-> flags_s1.valid_res)
		else $error("sequence added on empty pull");

	a_bank_release: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_pull && pull_valid && pull_end) |=> !bank_full_q[$past(read_bank_q)])
		else $error("bank not released after last sample");
`endif

endmodule

@@ rtl/ofdmcp_back.sv @@
// back part: sequence scaling, add, saturation and output register
module ofdmcp_back #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_valid,
	output logic                                 q_pop,
	input  ofdmcp_pkg::pull_flags_t              q_flags,
	input  logic signed [SAMPLE_BITS-1:0]        q_smp_re,
	input  logic signed [SAMPLE_BITS-1:0]        q_smp_im,
	input  logic signed [ofdmcp_pkg::ENTRY_W-1:0] q_ent_re,
	input  logic signed [ofdmcp_pkg::ENTRY_W-1:0] q_ent_im,
	input  logic [ofdmcp_pkg::GAIN_W-1:0]        sync_gain,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic signed [SAMPLE_BITS-1:0]        out_re,
	output logic signed [SAMPLE_BITS-1:0]        out_im,
	output logic                                 symbol_end,
	output ofdmcp_pkg::out_flags_t               out_flags
);

	import ofdmcp_pkg::*;

	localparam int PROD_W = ENTRY_W + GAIN_W + 1;
	localparam int RND_W  = PROD_W + 1;
	localparam int ADD_W  = RND_W - GAIN_FRAC;
	localparam int SUM_W  = ((SAMPLE_BITS > ADD_W) ? SAMPLE_BITS : ADD_W) + 1;
	localparam logic signed [RND_W-1:0] ROUND_HALF = RND_W'(1 << (GAIN_FRAC - 1));
	localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(1 << (SAMPLE_BITS - 1)));

	function automatic logic [SAMPLE_BITS:0] saturate(input logic signed [SUM_W-1:0] v);
		logic [SAMPLE_BITS:0] r;
		if (v > SAT_HI) begin
			r = {1'b1, SAT_HI[SAMPLE_BITS-1:0]};
		end else if (v < SAT_LO) begin
			r = {1'b1, SAT_LO[SAMPLE_BITS-1:0]};
		end else begin
			r = {1'b0, v[SAMPLE_BITS-1:0]};
		end
		return r;
	endfunction

	logic                           valid_s1;
	pull_flags_t                    flags_s1;
	logic signed [SAMPLE_BITS-1:0]  smp_re_s1, smp_im_s1;
	logic signed [PROD_W-1:0]       prod_re_s1, prod_im_s1;

	logic                           valid_s2;
	logic signed [SAMPLE_BITS-1:0]  out_re_s2, out_im_s2;
	logic                           end_s2;
	out_flags_t                     oflags_s2;

	logic                           adv1, adv2;
	logic signed [RND_W-1:0]        rnd_re, rnd_im;
	logic signed [ADD_W-1:0]        add_re, add_im;
	logic signed [SUM_W-1:0]        sum_re, sum_im;
	logic [SAMPLE_BITS:0]           sat_re, sat_im;

	assign adv2  = !valid_s2 || m_tready;
	assign adv1  = !valid_s1 || adv2;
	assign q_pop = q_valid && adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= q_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			flags_s1   <= q_flags;
			smp_re_s1  <= q_smp_re;
			smp_im_s1  <= q_smp_im;
			prod_re_s1 <= PROD_W'(q_ent_re) * $signed({1'b0, sync_gain});
			prod_im_s1 <= PROD_W'(q_ent_im) * $signed({1'b0, sync_gain});
		end
	end

	// round half up, then add in sample units
	always_comb begin
		rnd_re = RND_W'(prod_re_s1) + ROUND_HALF;
		rnd_im = RND_W'(prod_im_s1) + ROUND_HALF;
		add_re = flags_s1.add_en ? rnd_re[RND_W-1:GAIN_FRAC] : '0;
		add_im = flags_s1.add_en ? rnd_im[RND_W-1:GAIN_FRAC] : '0;
		sum_re = SUM_W'(smp_re_s1) + SUM_W'(add_re);
		sum_im = SUM_W'(smp_im_s1) + SUM_W'(add_im);
		sat_re = saturate(sum_re);
		sat_im = saturate(sum_im);
	end

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			if (flags_s1.valid_res) begin
				out_re_s2         <= sat_re[SAMPLE_BITS-1:0];
				out_im_s2         <= sat_im[SAMPLE_BITS-1:0];
				oflags_s2.clipped <= sat_re[SAMPLE_BITS] || sat_im[SAMPLE_BITS];
			end else begin
				out_re_s2         <= '0;
				out_im_s2         <= '0;
				oflags_s2.clipped <= 1'b0;
			end
			oflags_s2.valid_res <= flags_s1.valid_res;
			oflags_s2.overrun   <= flags_s1.overrun;
			end_s2              <= flags_s1.symbol_end;
		end
	end

	assign m_tvalid   = valid_s2;
	assign out_re     = out_re_s2;
	assign out_im     = out_im_s2;
	assign symbol_end = end_s2;
	assign out_flags  = oflags_s2;

endmodule
